[src/crt_test_pattern_pixel_generator_core_defines.svh]
// Assertion macros for the CRT test pattern pixel generator.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef CRT_TEST_PATTERN_PIXEL_GENERATOR_CORE_DEFINES_SVH
`define CRT_TEST_PATTERN_PIXEL_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication
`define CRTPG_ASSERT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define CRTPG_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[src/crtpg_pkg.sv]
// Package of the CRT test pattern pixel generator: widths, codes, tables,
// pipeline payload types and the divider step. No dependencies.
package crtpg_pkg;

  localparam int unsigned LINE_W     = 10;
  localparam int unsigned X_W        = 11;
  localparam int unsigned INT_W      = 2;
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned M_TDATA_W  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CELL_W     = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN   = 3'd0,
    REG_PIC_W     = 3'd1,
    REG_PIC_H     = 3'd2,
    REG_ACT_START = 3'd3,
    REG_SIG_W     = 3'd4,
    REG_CELL_W    = 3'd5,
    REG_CELL_H    = 3'd6,
    REG_REFRESH   = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PAT_DARK    = 3'd0,
    PAT_BARS    = 3'd1,
    PAT_FOCUS   = 3'd2,
    PAT_FULL    = 3'd3,
    PAT_SQUARES = 3'd4,
    PAT_CODE    = 3'd5
  } pattern_e;

  typedef enum logic [INT_W-1:0] {
    LVL_OFF    = 2'd0,
    LVL_DIM    = 2'd1,
    LVL_NORMAL = 2'd2,
    LVL_BOLD   = 2'd3
  } level_e;

  localparam logic [2:0]  RST_PATTERN   = PAT_DARK;
  localparam logic [10:0] RST_PIC_W     = 11'd1188;
  localparam logic [9:0]  RST_PIC_H     = 10'd416;
  localparam logic [9:0]  RST_ACT_START = 10'd20;
  localparam logic [10:0] RST_SIG_W     = 11'd1500;
  localparam logic [5:0]  RST_CELL_W    = 6'd9;
  localparam logic [5:0]  RST_CELL_H    = 6'd16;

  localparam int unsigned CELL_W_MIN    = 8;
  localparam int unsigned CELL_H_MIN    = 11;
  localparam int unsigned GRID_ROWS     = 26;
  localparam int unsigned GRID_MARK_ROW = 12;
  localparam int unsigned GLYPH_W       = 7;
  localparam int unsigned GLYPH_H       = 10;
  localparam int unsigned SQUARE_HALF   = 40;
  localparam int unsigned CROSS_ARM     = 12;
  localparam int unsigned FILL_W_60     = 225;
  localparam int unsigned FILL_W_78     = 226;
  localparam int unsigned FILL_H_60     = 170;
  localparam int unsigned FILL_H_78     = 157;
  localparam int unsigned BOX_SCALE     = 100;
  localparam int unsigned CODE_GROUP_PX  = 100;
  localparam int unsigned CODE_COLUMN_PX = 20;
  localparam int unsigned CODE_STRIDE_W = 3;

  // floor(v/100) = (v*1311) >> 17 for v < 2048; floor(v/20) = (v*205) >> 12 for v < 100
  localparam int unsigned RECIP_100    = 1311;
  localparam int unsigned RECIP_100_SH = 17;
  localparam int unsigned RECIP_20     = 205;
  localparam int unsigned RECIP_20_SH  = 12;
  localparam int unsigned GRP_W        = 5;
  localparam int unsigned OFF_W        = 7;
  localparam int unsigned COLN_W       = 3;
  localparam int unsigned R20_W        = 5;

  localparam logic [GLYPH_W-1:0] GLYPH_ROWS [GLYPH_H] = '{
    7'b1000001, 7'b1000001, 7'b1000001, 7'b1000001, 7'b1111111,
    7'b1000001, 7'b1000001, 7'b1000001, 7'b1000001, 7'b1000001
  };

  // quotient by compare and subtract against den << k, two steps per stage
  localparam int unsigned DIV_Q_W  = 10;
  localparam int unsigned DIV_R_W  = 18;
  localparam int unsigned DIV_D_W  = 8;
  localparam int unsigned NUM_DIV  = 5;
  localparam int unsigned DIV_X    = 0;
  localparam int unsigned DIV_Y    = 1;
  localparam int unsigned DIV_COLS = 2;
  localparam int unsigned DIV_BW   = 3;
  localparam int unsigned DIV_BH   = 4;

  localparam int unsigned COORD_W = 13;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [DIV_R_W-1:0] rem;
    logic [DIV_Q_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [X_W-1:0]    x;
    logic [LINE_W-1:0] y;
    logic              rows;
    logic              act;
    logic [GRP_W-1:0]  g;
    logic [OFF_W-1:0]  off;
    logic [COLN_W-1:0] n;
    logic [R20_W-1:0]  r20;
    logic              every_g;
    logic              g_ok;
  } item_t;

  typedef struct packed {
    logic             act;
    logic [INT_W-1:0] bars;
    logic [INT_W-1:0] focus;
    logic [INT_W-1:0] squares;
    logic [INT_W-1:0] code;
  } levels_t;

  function automatic div_t div_step(div_t a, logic [DIV_D_W-1:0] den, logic [3:0] idx);
    logic [DIV_R_W-1:0] sub;
    div_t r;
    r   = a;
    sub = DIV_R_W'(den) << idx;
    if (a.rem >= sub) begin
      r.rem      = a.rem - sub;
      r.quo[idx] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic on_outline(coord_t x, coord_t y, coord_t x0, coord_t y0,
                                      coord_t x1, coord_t y1);
    logic h_edge, v_edge;
    h_edge = (y == y0 || y == y1) && x >= x0 && x <= x1;
    v_edge = (x == x0 || x == x1) && y >= y0 && y <= y1;
    return h_edge || v_edge;
  endfunction

endpackage

[src/crt_test_pattern_pixel_generator_core.sv]
// Words accepted on s_axis pass every stage register in order, one pixel per
// cycle while m_axis is ready; the depth comes from the 10-bit quotient
// dividers (cell index, column count, box size) at two steps per stage.
// Stages stall one by one, so bubbles close up behind a held output word.
// Reset (rst_ni low, asynchronous): pipeline empty, registers to defaults.
`include "crt_test_pattern_pixel_generator_core_defines.svh"

module crt_test_pattern_pixel_generator_core
  import crtpg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [9:0] pixel_line, [20:10] pixel_x
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [1:0] intensity
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [2:0]  pattern_q;
  logic [10:0] pic_w_q;
  logic [9:0]  pic_h_q;
  logic [9:0]  act_start_q;
  logic [10:0] sig_w_q;
  logic [5:0]  cell_w_q;
  logic [5:0]  cell_h_q;
  logic        refresh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q   <= RST_PATTERN;
      pic_w_q     <= RST_PIC_W;
      pic_h_q     <= RST_PIC_H;
      act_start_q <= RST_ACT_START;
      sig_w_q     <= RST_SIG_W;
      cell_w_q    <= RST_CELL_W;
      cell_h_q    <= RST_CELL_H;
      refresh_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PATTERN:   pattern_q   <= cfg_data_i[2:0];
        REG_PIC_W:     pic_w_q     <= cfg_data_i[10:0];
        REG_PIC_H:     pic_h_q     <= cfg_data_i[9:0];
        REG_ACT_START: act_start_q <= cfg_data_i[9:0];
        REG_SIG_W:     sig_w_q     <= cfg_data_i[10:0];
        REG_CELL_W:    cell_w_q    <= cfg_data_i[5:0];
        REG_CELL_H:    cell_h_q    <= cfg_data_i[5:0];
        REG_REFRESH:   refresh_q   <= cfg_data_i[0];
        default:       pattern_q   <= pattern_q;
      endcase
    end
  end

  // static values from the registers
  logic [CELL_W-1:0]  cw_eff, ch_eff;
  logic [DIV_D_W-1:0] den [NUM_DIV];
  logic [DIV_R_W-1:0] bw_num, bh_num;
  logic [10:0]        bar_e1, bar_e2, bar_e3;
  logic [27:0]        grp_prod;
  logic [GRP_W-1:0]   groups;
  coord_t             cx, cy, pw_m1, ph_m1;

  always_comb begin
    cw_eff = (cell_w_q < CELL_W'(CELL_W_MIN)) ? CELL_W'(CELL_W_MIN) : cell_w_q;
    ch_eff = (cell_h_q < CELL_W'(CELL_H_MIN)) ? CELL_W'(CELL_H_MIN) : cell_h_q;
    den[DIV_X]    = DIV_D_W'(cw_eff);
    den[DIV_Y]    = DIV_D_W'(ch_eff);
    den[DIV_COLS] = DIV_D_W'(cw_eff);
    den[DIV_BW]   = refresh_q ? DIV_D_W'(FILL_W_78) : DIV_D_W'(FILL_W_60);
    den[DIV_BH]   = refresh_q ? DIV_D_W'(FILL_H_78) : DIV_D_W'(FILL_H_60);
    bw_num = DIV_R_W'(pic_w_q) * DIV_R_W'(BOX_SCALE) + DIV_R_W'(den[DIV_BW] >> 1);
    bh_num = DIV_R_W'(pic_h_q) * DIV_R_W'(BOX_SCALE) + DIV_R_W'(den[DIV_BH] >> 1);
    bar_e1 = 11'(pic_h_q >> 2);
    bar_e2 = bar_e1 + 11'(pic_h_q >> 2) + ((pic_h_q[1:0] >= 2'd3) ? 11'd1 : 11'd0);
    bar_e3 = bar_e2 + 11'(pic_h_q >> 2) + ((pic_h_q[1:0] >= 2'd2) ? 11'd1 : 11'd0);
    grp_prod = 28'(sig_w_q) * 28'(RECIP_100);
    groups   = grp_prod[RECIP_100_SH +: GRP_W];
    cx    = coord_t'({2'b00, pic_w_q} >> 1);
    cy    = coord_t'({3'b000, pic_h_q} >> 1);
    pw_m1 = coord_t'({2'b00, pic_w_q}) - coord_t'(1);
    ph_m1 = coord_t'({3'b000, pic_h_q}) - coord_t'(1);
  end

  // stage handshake: a stage loads when empty or when the next one moves
  logic [8:1] v_q;
  logic [8:1] en;

  always_comb begin
    en[8] = !v_q[8] || m_axis_tready;
    for (int k = 7; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= s_axis_tvalid;
      for (int k = 2; k <= 8; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  item_t              item_d [1:6];
  item_t              item_q [1:6];
  div_t               div_d  [1:6][NUM_DIV];
  div_t               div_q  [1:6][NUM_DIV];
  logic [LINE_W-1:0]  in_line;
  logic [X_W-1:0]     in_x;
  logic [21:0]        gx_prod;
  logic [14:0]        n_prod;

  assign in_line = s_axis_tdata[LINE_W-1:0];
  assign in_x    = s_axis_tdata[LINE_W +: X_W];

  always_comb begin
    item_d[1]      = '0;
    item_d[1].line = in_line;
    item_d[1].x    = in_x;
    item_d[1].y    = in_line - act_start_q;
    item_d[1].rows = in_line >= act_start_q &&
                     {1'b0, in_line} < ({1'b0, act_start_q} + {1'b0, pic_h_q});
    item_d[1].act  = item_d[1].rows && in_x < pic_w_q;

    // group index by reciprocal
    item_d[2]   = item_q[1];
    gx_prod     = 22'(item_q[1].x) * 22'(RECIP_100);
    item_d[2].g = gx_prod[RECIP_100_SH +: GRP_W];

    item_d[3]         = item_q[2];
    item_d[3].off     = OFF_W'(item_q[2].x - 11'(item_q[2].g) * 11'(CODE_GROUP_PX));
    item_d[3].every_g = (11'(item_q[2].g) * 11'(CODE_GROUP_PX)) >= pic_w_q;
    item_d[3].g_ok    = item_q[2].g < groups;

    item_d[4]   = item_q[3];
    n_prod      = 15'(item_q[3].off) * 15'(RECIP_20);
    item_d[4].n = n_prod[RECIP_20_SH +: COLN_W];

    item_d[5]     = item_q[4];
    item_d[5].r20 = R20_W'(item_q[4].off - OFF_W'(item_q[4].n) * OFF_W'(CODE_COLUMN_PX));

    item_d[6] = item_q[5];
  end

  always_comb begin
    for (int j = 0; j < NUM_DIV; j++) begin
      div_d[1][j].quo = '0;
    end
    div_d[1][DIV_X].rem    = DIV_R_W'(in_x);
    div_d[1][DIV_Y].rem    = DIV_R_W'(item_d[1].y);
    div_d[1][DIV_COLS].rem = DIV_R_W'(pic_w_q);
    div_d[1][DIV_BW].rem   = bw_num;
    div_d[1][DIV_BH].rem   = bh_num;
    for (int s = 2; s <= 6; s++) begin
      for (int j = 0; j < NUM_DIV; j++) begin
        div_d[s][j] = div_step(div_step(div_q[s-1][j], den[j], 4'(13 - 2 * s)),
                               den[j], 4'(12 - 2 * s));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 1; k <= 6; k++) begin
      if (en[k]) begin
        item_q[k] <= item_d[k];
        div_q[k]  <= div_d[k];
      end
    end
  end

  // stage 7: per-pattern levels
  levels_t lv_d, lv_q;

  always_comb begin
    item_t               it;
    logic [7:0]          col, row, cols, mark_col;
    logic [CELL_W-1:0]   gx, gy;
    logic                f_in, glyph_on;
    logic [3:0]          gy_idx;
    logic [2:0]          gx_bit;
    coord_t              xs, ys, hbw, hbh;
    logic                cross_hit, sq80, box, border;
    logic                every;
    logic [3:0]          ca, cb, cc, cd, k;

    it = item_q[6];

    lv_d     = '0;
    lv_d.act = it.act;

    if ({1'b0, it.y} < bar_e1)      lv_d.bars = LVL_OFF;
    else if ({1'b0, it.y} < bar_e2) lv_d.bars = LVL_DIM;
    else if ({1'b0, it.y} < bar_e3) lv_d.bars = LVL_NORMAL;
    else                            lv_d.bars = LVL_BOLD;

    col  = div_q[6][DIV_X].quo[7:0];
    gx   = div_q[6][DIV_X].rem[CELL_W-1:0];
    row  = div_q[6][DIV_Y].quo[7:0];
    gy   = div_q[6][DIV_Y].rem[CELL_W-1:0];
    cols = div_q[6][DIV_COLS].quo[7:0];
    mark_col = (cols - 8'd1) >> 1;
    f_in = col < cols && row < 8'(GRID_ROWS) &&
           gx >= CELL_W'(1) && gx <= CELL_W'(GLYPH_W) &&
           gy >= CELL_W'(1) && gy <= CELL_W'(GLYPH_H);
    gy_idx   = f_in ? 4'(gy - CELL_W'(1)) : 4'd0;
    gx_bit   = f_in ? 3'(CELL_W'(GLYPH_W) - gx) : 3'd0;
    glyph_on = f_in && GLYPH_ROWS[gy_idx][gx_bit];
    if (!glyph_on)                                          lv_d.focus = LVL_OFF;
    else if (col == mark_col && row == 8'(GRID_MARK_ROW)) lv_d.focus = LVL_BOLD;
    else                                                    lv_d.focus = LVL_NORMAL;

    xs  = coord_t'({2'b00, it.x});
    ys  = coord_t'({3'b000, it.y});
    hbw = coord_t'(div_q[6][DIV_BW].quo >> 1);
    hbh = coord_t'(div_q[6][DIV_BH].quo >> 1);
    cross_hit = (ys >= cy - coord_t'(1) && ys <= cy + coord_t'(1) &&
                 xs >= cx - coord_t'(CROSS_ARM) && xs <= cx + coord_t'(CROSS_ARM)) ||
                (xs >= cx - coord_t'(1) && xs <= cx + coord_t'(1) &&
                 ys >= cy - coord_t'(CROSS_ARM) && ys <= cy + coord_t'(CROSS_ARM));
    sq80 = on_outline(xs, ys, cx - coord_t'(SQUARE_HALF), cy - coord_t'(SQUARE_HALF),
                      cx + coord_t'(SQUARE_HALF) - coord_t'(1),
                      cy + coord_t'(SQUARE_HALF) - coord_t'(1));
    box  = on_outline(xs, ys, cx - hbw, cy - hbh,
                      cx + hbw - coord_t'(1), cy + hbh - coord_t'(1));
    border = xs == coord_t'(0) || ys == coord_t'(0) || xs == pw_m1 || ys == ph_m1;
    if (cross_hit)   lv_d.squares = LVL_BOLD;
    else if (sq80)   lv_d.squares = LVL_NORMAL;
    else if (box)    lv_d.squares = LVL_BOLD;
    else if (border) lv_d.squares = LVL_BOLD;
    else             lv_d.squares = LVL_OFF;

    ca = it.line[3:0];
    cb = it.line[7:4];
    cc = {2'b00, it.line[9:8]};
    cd = it.g[3:0];
    case (it.n)
      3'd0:    k = ca;
      3'd1:    k = cb;
      3'd2:    k = cc;
      3'd3:    k = cd;
      default: k = ca ^ cb ^ cc ^ cd;
    endcase
    every = !it.rows || it.every_g;
    if (!it.g_ok)
      lv_d.code = LVL_OFF;
    else if (!every && it.line[CODE_STRIDE_W-1:0] != it.g[CODE_STRIDE_W-1:0])
      lv_d.code = LVL_OFF;
    else if (it.r20 == {1'b0, k})
      lv_d.code = LVL_BOLD;
    else
      lv_d.code = LVL_OFF;
  end

  // stage 8: pattern select into the output register
  logic [INT_W-1:0] level_d, level_q;

  always_comb begin
    level_d = LVL_OFF;
    if (pattern_q == PAT_CODE) begin
      level_d = lv_q.code;
    end else if (lv_q.act) begin
      case (pattern_q)
        PAT_BARS:    level_d = lv_q.bars;
        PAT_FOCUS:   level_d = lv_q.focus;
        PAT_FULL:    level_d = LVL_BOLD;
        PAT_SQUARES: level_d = lv_q.squares;
        default:     level_d = LVL_OFF;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) lv_q <= lv_d;
    if (en[8]) level_q <= level_d;
  end

  assign m_axis_tvalid = v_q[8];
  assign m_axis_tdata  = {(M_TDATA_W - INT_W)'(0), level_q};

  `CRTPG_ASSERT_NEXT(a_accept_loads, s_axis_tvalid && s_axis_tready, v_q[1], "accepted word missing in stage 1")
  `CRTPG_ASSERT_NEXT(a_stall_keeps, v_q[8] && !m_axis_tready && v_q[7], v_q[7] && v_q[8], "word lost under output stall")
  `CRTPG_ASSERT_NEXT(a_stage7_moves, v_q[7] && en[7] && !(v_q[6] && en[6]), !v_q[7] && v_q[8], "word from stage 7 not in output register")

endmodule

[bench/crt_test_pattern_pixel_generator_core_tb.sv]
// Self-checking bench for crt_test_pattern_pixel_generator_core: a probe table,
// then random pixels over many register settings, with randomly idling stream sides.
// Depends on crtpg_pkg and the core; reads no files.
module crt_test_pattern_pixel_generator_core_tb
  import crtpg_pkg::*;
();

  localparam int CLK_PERIOD       = 8;
  localparam int RESET_CYCLES     = 11;
  localparam int LATENCY          = 8;
  localparam int MAX_WAIT         = 11;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int NUM_SETTINGS     = 16;
  localparam int PIXELS_PER_SET   = 26;
  localparam int QUIET_RUN        = 40;
  localparam logic [2:0] PAT_SPARE_A = 3'd6;
  localparam logic [2:0] PAT_SPARE_B = 3'd7;

  // signed copies of the geometry constants
  localparam int ARM      = CROSS_ARM;
  localparam int SQ_SIZE  = 2 * SQUARE_HALF;
  localparam int GROUP_PX = CODE_GROUP_PX;
  localparam int COLUMN_PX = CODE_COLUMN_PX;
  localparam int STRIDE   = 1 << CODE_STRIDE_W;
  localparam int MAX_LINE = (1 << LINE_W) - 1;
  localparam int MAX_X    = (1 << X_W) - 1;

  typedef struct packed {
    logic [2:0]        pat;
    logic [LINE_W-1:0] line;
    logic [X_W-1:0]    x;
    logic              known;
    logic [INT_W-1:0]  level;
  } probe_t;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [X_W-1:0]    x;
    logic [INT_W-1:0]  level;
  } pending_t;

  localparam int NUM_PROBES = 24;
  localparam probe_t PROBES [NUM_PROBES] = '{
    '{PAT_DARK,    10'd0,    11'd0,    1'b1, LVL_OFF},
    '{PAT_DARK,    10'd1023, 11'd2047, 1'b1, LVL_OFF},
    '{PAT_FULL,    10'd20,   11'd0,    1'b1, LVL_BOLD},
    '{PAT_FULL,    10'd435,  11'd1187, 1'b1, LVL_BOLD},
    '{PAT_FULL,    10'd19,   11'd0,    1'b1, LVL_OFF},
    '{PAT_FULL,    10'd436,  11'd0,    1'b1, LVL_OFF},
    '{PAT_FULL,    10'd20,   11'd1188, 1'b1, LVL_OFF},
    '{PAT_BARS,    10'd20,   11'd0,    1'b1, LVL_OFF},
    '{PAT_BARS,    10'd435,  11'd5,    1'b1, LVL_BOLD},
    '{PAT_BARS,    10'd124,  11'd10,   1'b0, LVL_OFF},
    '{PAT_BARS,    10'd332,  11'd700,  1'b0, LVL_OFF},
    '{PAT_FOCUS,   10'd21,   11'd1,    1'b0, LVL_OFF},
    '{PAT_FOCUS,   10'd213,  11'd586,  1'b0, LVL_OFF},
    '{PAT_FOCUS,   10'd25,   11'd5,    1'b0, LVL_OFF},
    '{PAT_FOCUS,   10'd435,  11'd1187, 1'b0, LVL_OFF},
    '{PAT_SQUARES, 10'd228,  11'd594,  1'b1, LVL_BOLD},
    '{PAT_SQUARES, 10'd20,   11'd0,    1'b1, LVL_BOLD},
    '{PAT_SQUARES, 10'd188,  11'd594,  1'b0, LVL_OFF},
    '{PAT_SQUARES, 10'd100,  11'd330,  1'b0, LVL_OFF},
    '{PAT_CODE,    10'd0,    11'd0,    1'b1, LVL_BOLD},
    '{PAT_CODE,    10'd1023, 11'd2047, 1'b1, LVL_OFF},
    '{PAT_CODE,    10'd300,  11'd1450, 1'b0, LVL_OFF},
    '{PAT_SPARE_A, 10'd228,  11'd594,  1'b1, LVL_OFF},
    '{PAT_SPARE_B, 10'd228,  11'd594,  1'b1, LVL_OFF}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;   // [9:0] pixel_line, [20:10] pixel_x
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;   // [1:0] intensity
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  crt_test_pattern_pixel_generator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // register shadow
  logic [2:0] cfg_pattern = RST_PATTERN;
  int pic_w      = RST_PIC_W;
  int pic_h      = RST_PIC_H;
  int act_start  = RST_ACT_START;
  int sig_w      = RST_SIG_W;
  int cell_w     = RST_CELL_W;
  int cell_h     = RST_CELL_H;
  int refresh_78 = 0;

  pending_t expected_levels [$];
  int errors   = 0;
  int sent     = 0;
  int received = 0;
  int cycles   = 0;
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;

  function automatic bit on_rect_edge(int x, int y, int x0, int y0, int x1, int y1);
    return ((y == y0 || y == y1) && x >= x0 && x <= x1) ||
           ((x == x0 || x == x1) && y >= y0 && y <= y1);
  endfunction

  function automatic bit on_centered_box(int x, int y, int cx, int cy, int w, int h);
    return on_rect_edge(x, y, cx - w / 2, cy - h / 2, cx + w / 2 - 1, cy + h / 2 - 1);
  endfunction

  // 100 mm box in pixels, rounded
  function automatic void box_size(output int bw, output int bh);
    int fw, fh;
    fw = refresh_78 ? FILL_W_78 : FILL_W_60;
    fh = refresh_78 ? FILL_H_78 : FILL_H_60;
    bw = (BOX_SCALE * pic_w + fw / 2) / fw;
    bh = (BOX_SCALE * pic_h + fh / 2) / fh;
  endfunction

  function automatic logic [INT_W-1:0] bar_level(int y);
    int base, rem, lim;
    base = pic_h / 4;
    rem  = pic_h % 4;
    lim  = base;
    if (y < lim) return LVL_OFF;
    lim += base + int'(rem >= 3);
    if (y < lim) return LVL_DIM;
    lim += base + int'(rem >= 2);
    if (y < lim) return LVL_NORMAL;
    return LVL_BOLD;
  endfunction

  function automatic logic [INT_W-1:0] grid_level(int x, int y);
    int cw, ch, cols, col, row, gx, gy;
    cw   = (cell_w < int'(CELL_W_MIN)) ? int'(CELL_W_MIN) : cell_w;
    ch   = (cell_h < int'(CELL_H_MIN)) ? int'(CELL_H_MIN) : cell_h;
    cols = pic_w / cw;
    col  = x / cw;
    row  = y / ch;
    gx   = x % cw;
    gy   = y % ch;
    if (col >= cols || row >= int'(GRID_ROWS)) return LVL_OFF;
    if (gx < 1 || gx > int'(GLYPH_W) || gy < 1 || gy > int'(GLYPH_H)) return LVL_OFF;
    // H glyph: both outer columns plus the crossbar on its fifth row
    if (!(gx == 1 || gx == int'(GLYPH_W) || gy == 5)) return LVL_OFF;
    return (col == (cols - 1) / 2 && row == int'(GRID_MARK_ROW)) ? LVL_BOLD : LVL_NORMAL;
  endfunction

  function automatic logic [INT_W-1:0] square_level(int x, int y);
    int cx, cy, bw, bh;
    cx = pic_w / 2;
    cy = pic_h / 2;
    box_size(bw, bh);
    if (y >= cy - 1 && y <= cy + 1 && x >= cx - ARM && x <= cx + ARM) return LVL_BOLD;
    if (x >= cx - 1 && x <= cx + 1 && y >= cy - ARM && y <= cy + ARM) return LVL_BOLD;
    if (on_centered_box(x, y, cx, cy, SQ_SIZE, SQ_SIZE)) return LVL_NORMAL;
    if (on_centered_box(x, y, cx, cy, bw, bh)) return LVL_BOLD;
    if (on_rect_edge(x, y, 0, 0, pic_w - 1, pic_h - 1)) return LVL_BOLD;
    return LVL_OFF;
  endfunction

  function automatic logic [INT_W-1:0] code_level(int line, int x);
    int groups, g, off, k;
    bit every;
    groups = sig_w / GROUP_PX;
    g      = x / GROUP_PX;
    off    = x % GROUP_PX;
    every  = line < act_start || line >= act_start + pic_h || g * GROUP_PX >= pic_w;
    if (g >= groups) return LVL_OFF;
    if (!every && (line % STRIDE) != (g % STRIDE)) return LVL_OFF;
    case (off / COLUMN_PX)
      0: k = line & 15;
      1: k = (line >> 4) & 15;
      2: k = (line >> 8) & 15;
      3: k = g & 15;
      default: k = (line ^ (line >> 4) ^ (line >> 8) ^ g) & 15;
    endcase
    return (off % COLUMN_PX == k) ? LVL_BOLD : LVL_OFF;
  endfunction

  function automatic logic [INT_W-1:0] pixel_level(logic [LINE_W-1:0] line,
                                                   logic [X_W-1:0] x);
    int l, px, y;
    bit active;
    l      = line;
    px     = x;
    y      = l - act_start;
    active = l >= act_start && l < act_start + pic_h && px < pic_w;
    if (cfg_pattern == PAT_CODE) return code_level(l, px);
    if (!active) return LVL_OFF;
    case (cfg_pattern)
      PAT_BARS:    return bar_level(y);
      PAT_FOCUS:   return grid_level(px, y);
      PAT_FULL:    return LVL_BOLD;
      PAT_SQUARES: return square_level(px, y);
      default:     return LVL_OFF;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("ERROR cycle %0d: %s", cycles, msg);
  endtask

  task automatic send_pixel(logic [LINE_W-1:0] line, logic [X_W-1:0] x, logic known,
                            logic [INT_W-1:0] level);
    int gap;
    if (sent % QUIET_RUN == 0) send_quiet = ($urandom_range(0, 2) == 0);
    gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({x, line});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_levels.push_back('{line, x, known ? level : pixel_level(line, x)});
    sent++;
  endtask

  task automatic write_reg(cfg_reg_e idx, int value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_PATTERN:   cfg_pattern = value[2:0];
      REG_PIC_W:     pic_w       = value & 2047;
      REG_PIC_H:     pic_h       = value & 1023;
      REG_ACT_START: act_start   = value & 1023;
      REG_SIG_W:     sig_w       = value & 2047;
      REG_CELL_W:    cell_w      = value & 63;
      REG_CELL_H:    cell_h      = value & 63;
      REG_REFRESH:   refresh_78  = value & 1;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic apply_setting(int p);
    logic [2:0] pat;
    int w, h, st, sw, cw, ch, rf;
    case (p)
      0: begin  // every register but the pattern at its top
        pat = PAT_CODE; w = 2047; h = 1023; st = 1023; sw = 2047; cw = 63; ch = 63; rf = 1;
      end
      1: begin  // empty picture
        pat = PAT_FULL; w = 0; h = 0; st = 0; sw = 0; cw = 0; ch = 0; rf = 0;
      end
      2: begin  // cells below the minimum size
        pat = PAT_FOCUS; w = 1188; h = 416; st = 20; sw = 1500; cw = 0; ch = 5; rf = 0;
      end
      3: begin  // shapes larger than the picture get clipped
        pat = PAT_SQUARES; w = 30; h = 20; st = 5; sw = 200; cw = 8; ch = 11; rf = 1;
      end
      4: begin
        pat = PAT_BARS; w = 2047; h = 1023; st = 0; sw = 2047; cw = 32; ch = 32; rf = 0;
      end
      default: begin
        pat = 3'(p % 8);
        w   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 2047);
        h   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 1023);
        st  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 60);
        sw  = $urandom_range(0, 2047);
        cw  = $urandom_range(0, 63);
        ch  = $urandom_range(0, 63);
        rf  = $urandom_range(0, 1);
      end
    endcase
    write_reg(REG_PATTERN, pat);
    write_reg(REG_PIC_W, w);
    write_reg(REG_PIC_H, h);
    write_reg(REG_ACT_START, st);
    write_reg(REG_SIG_W, sw);
    write_reg(REG_CELL_W, cw);
    write_reg(REG_CELL_H, ch);
    write_reg(REG_REFRESH, rf);
  endtask

  // offset toward the cross, the 80 px square or the box edge
  function automatic int near_feature(int c, int half);
    int sgn;
    sgn = $urandom_range(0, 1) ? 1 : -1;
    case ($urandom_range(0, 2))
      0:       return c + int'($urandom_range(0, 30)) - 15;
      1:       return c + sgn * (SQUARE_HALF + int'($urandom_range(0, 2)) - 1);
      default: return c + sgn * (half + int'($urandom_range(0, 2)) - 1);
    endcase
  endfunction

  task automatic random_pixel(output logic [LINE_W-1:0] line, output logic [X_W-1:0] x);
    int mode, hi, bw, bh, l, px;
    mode = $urandom_range(0, 9);
    l    = $urandom_range(0, MAX_LINE);
    px   = $urandom_range(0, MAX_X);
    if (mode >= 3 && pic_w > 0 && pic_h > 0 && act_start <= MAX_LINE) begin
      hi = act_start + pic_h - 1;
      if (hi > MAX_LINE) hi = MAX_LINE;
      l  = $urandom_range(act_start, hi);
      px = $urandom_range(0, pic_w - 1);
      if (mode >= 7) begin
        box_size(bw, bh);
        l  = act_start + near_feature(pic_h / 2, bh / 2);
        px = near_feature(pic_w / 2, bw / 2);
      end
    end
    line = (l < 0) ? 0 : (l > MAX_LINE) ? MAX_LINE : l;
    x    = (px < 0) ? 0 : (px > MAX_X) ? MAX_X : px;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycles,
               expected_levels.size());
      $display("crt_test_pattern_pixel_generator_core_tb failed");
      $finish;
    end
  end

  // result side: random stalls, compare against the oldest pending pixel
  initial begin
    int stall;
    pending_t want;
    logic [INT_W-1:0] got;
    @(posedge rst_ni);
    forever begin
      if (received % QUIET_RUN == 0) recv_quiet = ($urandom_range(0, 2) == 0);
      stall = recv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got = m_axis_tdata[INT_W-1:0];
      received++;
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("intensity %0d arrived with no pixel pending", got));
      end else begin
        want = expected_levels.pop_front();
        if (got !== want.level)
          report_mismatch($sformatf("line %0d x %0d pattern %0d: intensity %0d, expected %0d",
                                    want.line, want.x, cfg_pattern, got, want.level));
      end
    end
  end

  initial begin
    logic [LINE_W-1:0] line;
    logic [X_W-1:0]    x;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_PATTERN;
    cfg_data_i    = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NUM_PROBES; i++) begin
      if (PROBES[i].pat != cfg_pattern) begin
        wait_idle();
        write_reg(REG_PATTERN, PROBES[i].pat);
      end
      send_pixel(PROBES[i].line, PROBES[i].x, PROBES[i].known, PROBES[i].level);
    end

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      wait_idle();
      apply_setting(p);
      repeat (PIXELS_PER_SET) begin
        random_pixel(line, x);
        send_pixel(line, x, 1'b0, LVL_OFF);
      end
    end
    wait_idle();

    $display("%0d pixels checked: %0d table probes, then %0d register settings", sent,
             NUM_PROBES, NUM_SETTINGS);
    $display("covering every pattern, unused selectors, empty and clipped pictures; %0d errors",
             errors);
    if (errors == 0) begin
      $display("crt_test_pattern_pixel_generator_core_tb passed");
    end else begin
      $display("crt_test_pattern_pixel_generator_core_tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/crtpg_pkg.sv
src/crt_test_pattern_pixel_generator_core.sv
bench/crt_test_pattern_pixel_generator_core_tb.sv
